// File: rtl/adsr_pkg.sv
// Package for the ADSR waveform voice: widths, codes, the configuration
// struct and the constant sine table. Used by the front end, the back end and the top level.
package adsr_pkg;

   localparam int PHASE_BITS    = 24;
   localparam int TIME_BITS     = 24;
   localparam int SINE_DEPTH    = 256;
   localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
   localparam int LEVEL_BITS    = 16;
   localparam int STEP_BITS     = 23;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DIV_STEPS     = 16;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

   localparam logic [14:0] FULL_SCALE = 15'd32767;
   localparam logic [15:0] UNITY      = 16'd32768;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WAVEFORM      = 3'd0,
      REG_PHASE_STEP    = 3'd1,
      REG_ATTACK_LEVEL  = 3'd2,
      REG_SUSTAIN_LEVEL = 3'd3,
      REG_ATTACK_LEN    = 3'd4,
      REG_DECAY_LEN     = 3'd5,
      REG_SUSTAIN_LEN   = 3'd6,
      REG_RELEASE_LEN   = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAW      = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      SEG_ATTACK  = 2'd0,
      SEG_DECAY   = 2'd1,
      SEG_SUSTAIN = 2'd2,
      SEG_RELEASE = 2'd3
   } segment_type;

   typedef struct packed {
      wave_type                        waveform;
      logic [STEP_BITS-1:0]            phase_step;
      logic [LEVEL_BITS-1:0]           attack_level;
      logic [LEVEL_BITS-1:0]           sustain_level;
      logic [3:0][TIME_BITS-1:0]       seg_len;
   } cfg_type;

   // One entry of the request queue as seen by the back end.
   typedef struct packed {
      logic valid;
      logic start;
   } qitem_type;

   typedef logic signed [15:0] sine_tab_type [SINE_DEPTH];

   // Fixed-point odd series for sine; defines every table entry exactly.
   function automatic logic signed [15:0] sine_entry(int idx);
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] w;
      logic        neg;
      t   = (64'(idx) << 32) / SINE_DEPTH;
      neg = 1'b0;
      if (t >= (64'd1 << 31)) begin
         neg = 1'b1;
         t   = t - (64'd1 << 31);
      end
      if (t > (64'd1 << 30)) begin
         t = (64'd1 << 31) - t;
      end
      x  = (t * 64'd6746518852) >> 32;
      x2 = (x * x) >> 30;
      r  = 64'd1 << 30;
      r  = (64'd1 << 30) - ((x2 * r) >> 30) / 110;
      r  = (64'd1 << 30) - ((x2 * r) >> 30) / 72;
      r  = (64'd1 << 30) - ((x2 * r) >> 30) / 42;
      r  = (64'd1 << 30) - ((x2 * r) >> 30) / 20;
      r  = (64'd1 << 30) - ((x2 * r) >> 30) / 6;
      s  = (x * r) >> 30;
      w  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (w > 64'd32767) begin
         w = 64'd32767;
      end
      return neg ? -(16'(w)) : 16'(w);
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         tab[i] = sine_entry(i);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_sine();

endpackage

// File: rtl/adsr_front.sv
// Front end of the ADSR voice: accepts request transactions into a short
// queue that the back end drains. Depends on adsr_pkg.
module adsr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_start_req,
   input  logic                 pop,
   output adsr_pkg::qitem_type  head
);

   localparam int PTR_BITS = $clog2(adsr_pkg::QUEUE_DEPTH);

   logic [adsr_pkg::QUEUE_DEPTH-1:0] mem_ff;
   logic [PTR_BITS-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]                count_ff, count_in;
   logic                             push;
   logic                             take;

   assign req_ready  = (count_ff != (PTR_BITS+1)'(adsr_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head.valid = (count_ff != '0);
   assign head.start = mem_ff[rd_ptr_ff];
   assign take       = pop && head.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_start_req;
      end
   end

endmodule

// File: rtl/adsr_engine.sv
// Back end of the ADSR voice: voice state, waveform lookup, envelope
// divider, output multiply and the result register. Depends on adsr_pkg.
module adsr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  adsr_pkg::cfg_type    cfg,
   input  adsr_pkg::qitem_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_sample,
   output logic                 rsp_active,
   output logic                 rsp_last
);

   localparam int PB = adsr_pkg::PHASE_BITS;
   localparam int TB = adsr_pkg::TIME_BITS;
   localparam int NB = adsr_pkg::LEVEL_BITS + TB;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_WAVE  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic        play;
      logic [1:0]  seg;
   } enter_type;

   // First segment with nonzero length at or after 'from'.
   function automatic enter_type enter_seg(logic [2:0] from,
                                           logic [3:0][TB-1:0] lens);
      enter_type res;
      res.play = 1'b0;
      res.seg  = 2'd0;
      for (int k = 3; k >= 0; k--) begin
         if ((3'(k) >= from) && (lens[k] != '0)) begin
            res.play = 1'b1;
            res.seg  = 2'(k);
         end
      end
      return res;
   endfunction

   state_type                   state_ff, state_in;
   logic                        start_ff;
   logic [PB-1:0]               phase_ff;
   logic [1:0]                  seg_ff;
   logic [TB-1:0]               pos_ff;
   logic                        playing_ff;
   logic                        idle_ff;
   logic signed [15:0]          wave_ff;
   logic [adsr_pkg::LEVEL_BITS-1:0] x_ff;
   logic [TB-1:0]               n_ff;
   logic [TB-1:0]               len_ff;
   logic [16:0]                 base_ff;
   logic                        sub_ff;
   logic [NB-1:0]               num_ff;
   logic [TB-1:0]               rem_ff;
   logic [15:0]                 quo_ff;
   logic [adsr_pkg::DIV_CNT_BITS-1:0] cnt_ff;
   logic signed [33:0]          prod_ff;
   logic                        rsp_valid_ff;
   logic signed [15:0]          rsp_sample_ff;
   logic                        rsp_active_ff;
   logic                        rsp_last_ff;

   logic [15:0]                 lvl_a, lvl_s;
   logic [TB-1:0]               cur_len;
   logic signed [15:0]          wave_val;
   logic [PB+13:0]              tri_prod;
   logic [PB+14:0]              saw_prod;
   logic [14:0]                 tri_r, saw_r;
   logic [TB:0]                 trial;
   logic [16:0]                 env;
   logic [33:0]                 prod_mag;
   logic [15:0]                 mag;
   logic signed [15:0]          smp;
   logic [TB-1:0]               pos_next;
   enter_type                   start_ent, next_ent;
   logic                        seg_end;
   logic                        out_free;

   assign lvl_a   = (cfg.attack_level > adsr_pkg::UNITY) ? adsr_pkg::UNITY
                                                        : cfg.attack_level;
   assign lvl_s   = (cfg.sustain_level > adsr_pkg::UNITY) ? adsr_pkg::UNITY
                                                         : cfg.sustain_level;
   assign cur_len = cfg.seg_len[seg_ff];

   // Waveform from the phase before this sample's advance.
   always_comb begin
      tri_prod = (PB+14)'(phase_ff[PB-3:0]) * (PB+14)'(adsr_pkg::FULL_SCALE);
      saw_prod = (PB+15)'(phase_ff[PB-2:0]) * (PB+15)'(adsr_pkg::FULL_SCALE);
      tri_r    = tri_prod[PB+12 -: 15];
      saw_r    = saw_prod[PB+13 -: 15];
      case (cfg.waveform)
         adsr_pkg::WAVE_SINE: begin
            wave_val = adsr_pkg::SINE_TABLE[phase_ff[PB-1 -: adsr_pkg::SINE_IDX_BITS]];
         end
         adsr_pkg::WAVE_SQUARE: begin
            wave_val = (!phase_ff[PB-1] && (phase_ff != '0))
                       ? $signed({1'b0, adsr_pkg::FULL_SCALE})
                       : -$signed({1'b0, adsr_pkg::FULL_SCALE});
         end
         adsr_pkg::WAVE_TRIANGLE: begin
            case (phase_ff[PB-1:PB-2])
               2'd0:    wave_val = $signed({1'b0, tri_r});
               2'd1:    wave_val = $signed({1'b0, adsr_pkg::FULL_SCALE - tri_r});
               2'd2:    wave_val = -$signed({1'b0, tri_r});
               default: wave_val = $signed({1'b0, tri_r})
                                   - $signed({1'b0, adsr_pkg::FULL_SCALE});
            endcase
         end
         default: begin
            wave_val = phase_ff[PB-1] ? $signed({1'b0, saw_r})
                                        - $signed({1'b0, adsr_pkg::FULL_SCALE})
                                      : $signed({1'b0, saw_r});
         end
      endcase
   end

   always_comb begin
      trial    = {rem_ff, num_ff[adsr_pkg::DIV_STEPS-1]} - {1'b0, len_ff};
      env      = sub_ff ? base_ff - {1'b0, quo_ff} : base_ff + {1'b0, quo_ff};
      prod_mag = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);
      mag      = prod_mag[30:15];
      smp      = prod_ff[33] ? -$signed(mag) : $signed(mag);
      pos_next = pos_ff + 1'b1;
      seg_end  = (pos_next == '0) || (pos_next >= cur_len);
      next_ent = enter_seg({1'b0, seg_ff} + 3'd1, cfg.seg_len);
      start_ent = enter_seg(3'd0, cfg.seg_len);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   assign pop = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (head.valid) state_in = ST_PREP;
         ST_PREP:  state_in = ST_WAVE;
         ST_WAVE:  state_in = playing_ff ? ST_MUL : ST_DONE;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == '1) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         seg_ff       <= adsr_pkg::SEG_ATTACK;
         pos_ff       <= '0;
         playing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         // A new result loaded in the same cycle keeps the valid flag set.
         if (rsp_valid_ff && rsp_ready && !((state_ff == ST_DONE) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_PREP: begin
               if (start_ff) begin
                  phase_ff   <= '0;
                  seg_ff     <= start_ent.seg;
                  pos_ff     <= '0;
                  playing_ff <= start_ent.play;
               end
            end
            ST_MUL: begin
               cnt_ff <= '0;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (!idle_ff) begin
                     phase_ff <= PB'(phase_ff + PB'(cfg.phase_step));
                     if (seg_end) begin
                        seg_ff     <= next_ent.seg;
                        pos_ff     <= '0;
                        playing_ff <= next_ent.play;
                     end else begin
                        pos_ff <= pos_next;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            start_ff <= head.start;
         end
         ST_WAVE: begin
            idle_ff <= !playing_ff;
            wave_ff <= wave_val;
            if (cur_len == '0) begin
               n_ff   <= TB'(1);
               len_ff <= TB'(1);
            end else begin
               n_ff   <= (pos_ff > cur_len) ? cur_len : pos_ff;
               len_ff <= cur_len;
            end
            case (seg_ff)
               adsr_pkg::SEG_ATTACK: begin
                  x_ff <= lvl_a; base_ff <= '0; sub_ff <= 1'b0;
               end
               adsr_pkg::SEG_DECAY: begin
                  base_ff <= {1'b0, lvl_a};
                  sub_ff  <= (lvl_a >= lvl_s);
                  x_ff    <= (lvl_a >= lvl_s) ? lvl_a - lvl_s : lvl_s - lvl_a;
               end
               adsr_pkg::SEG_SUSTAIN: begin
                  x_ff <= '0; base_ff <= {1'b0, lvl_s}; sub_ff <= 1'b0;
               end
               default: begin
                  x_ff <= lvl_s; base_ff <= {1'b0, lvl_s}; sub_ff <= 1'b1;
               end
            endcase
         end
         ST_MUL: begin
            rem_ff <= '0;
         end
         default: begin
         end
      endcase
      // The quotient fits in 16 bits, so the top of the product is
      // already below the divisor and only 16 steps remain.
      if (state_ff == ST_MUL) begin
         num_ff <= NB'(x_ff) * NB'(n_ff);
      end
      if (state_ff == ST_DIV) begin
         if (cnt_ff == '0) begin
            // First step starts from the upper bits of the product.
            if ({num_ff[NB-1:adsr_pkg::DIV_STEPS-1]} >= {1'b0, len_ff}) begin
               rem_ff <= TB'({num_ff[NB-1:adsr_pkg::DIV_STEPS-1]} - {1'b0, len_ff});
               quo_ff <= 16'd1;
            end else begin
               rem_ff <= num_ff[NB-2:adsr_pkg::DIV_STEPS-1];
               quo_ff <= 16'd0;
            end
         end else begin
            if (!trial[TB]) begin
               rem_ff <= trial[TB-1:0];
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[TB-2:0], num_ff[adsr_pkg::DIV_STEPS-1]};
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
         end
         num_ff <= {num_ff[NB-2:0], 1'b0};
      end
      if (state_ff == ST_SCALE) begin
         prod_ff <= $signed({1'b0, env}) * 34'(wave_ff);
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_sample_ff <= idle_ff ? 16'sd0 : smp;
         rsp_active_ff <= !idle_ff;
         rsp_last_ff   <= !idle_ff && seg_end && !next_ent.play;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: rtl/adsr_waveform_voice_top.sv
// Top level of the ADSR waveform voice: configuration registers and the
// front/back split. Depends on adsr_pkg, adsr_front and adsr_engine.
//
// Usage: each request transaction (req_valid/req_ready, req_start_req)
// yields exactly one response transaction (rsp_valid/rsp_ready) carrying
// one signed sample, the active flag and the last-sample flag.
// req_start_req = 1 restarts the note at sample zero; 0 advances one tick.
// Registers are written through csr_valid/csr_index/csr_data; csr_ready is
// always high. Write them only while no transaction is in flight.
// The back end works on one request at a time, in order: prepare, waveform
// lookup, multiply, the 16-step restoring divider that scales the envelope
// segment, output scaling and the final step; a silent voice goes from the lookup to the final step.
// A two-entry queue lets requests be accepted while the back end works, and
// a response register holds a finished sample while the receiver stalls;
// the back end waits in its final step until that register frees.
// Reset clears all registers, the voice state, the request queue and the
// response valid flag; the voice comes up silent.
module adsr_waveform_voice_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_sample,
   output logic                                rsp_active,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adsr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   adsr_pkg::cfg_type   cfg_ff;
   adsr_pkg::qitem_type head;
   logic                pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (adsr_pkg::csr_reg_type'(csr_index))
            adsr_pkg::REG_WAVEFORM:
               cfg_ff.waveform <= adsr_pkg::wave_type'(csr_data[1:0]);
            adsr_pkg::REG_PHASE_STEP:
               cfg_ff.phase_step <= csr_data[adsr_pkg::STEP_BITS-1:0];
            adsr_pkg::REG_ATTACK_LEVEL:
               cfg_ff.attack_level <= csr_data[adsr_pkg::LEVEL_BITS-1:0];
            adsr_pkg::REG_SUSTAIN_LEVEL:
               cfg_ff.sustain_level <= csr_data[adsr_pkg::LEVEL_BITS-1:0];
            adsr_pkg::REG_ATTACK_LEN:
               cfg_ff.seg_len[0] <= adsr_pkg::TIME_BITS'(csr_data);
            adsr_pkg::REG_DECAY_LEN:
               cfg_ff.seg_len[1] <= adsr_pkg::TIME_BITS'(csr_data);
            adsr_pkg::REG_SUSTAIN_LEN:
               cfg_ff.seg_len[2] <= adsr_pkg::TIME_BITS'(csr_data);
            adsr_pkg::REG_RELEASE_LEN:
               cfg_ff.seg_len[3] <= adsr_pkg::TIME_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   adsr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_req (req_start_req),
      .pop           (pop),
      .head          (head)
   );

   adsr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .rsp_active (rsp_active),
      .rsp_last   (rsp_last)
   );

endmodule

// File: rtl/adsr_checker.sv
// Port-level checks for the ADSR waveform voice, bound to the top level.
// Depends only on the top level's ports.
module adsr_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_sample,
   input logic               rsp_active,
   input logic               rsp_last
);

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_active) && $stable(rsp_last))
      else $error("response changed while stalled");

   // A silent voice gives a zero sample and never flags the note end.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == 16'sd0 && !rsp_last)
      else $error("idle response is not silent");

   a_last_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_active)
      else $error("last flag on an inactive sample");

   // The sample magnitude never reaches full negative scale.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample != -16'sd32768)
      else $error("sample out of range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind adsr_waveform_voice_top adsr_checker u_adsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample),
   .rsp_active (rsp_active),
   .rsp_last   (rsp_last)
);

// File: dv/testbench.sv
// Self-checking testbench for adsr_waveform_voice_top: a directed table, then
// random notes under random configurations, checked against typed table values or an in-bench voice model.
// Depends on adsr_pkg and the RTL of the voice.
`timescale 1ns / 100ps

module testbench;

   localparam int CLK_HALF   = 4;
   localparam int DRAIN_WAIT = 40;

   typedef struct {
      logic signed [15:0] sample;
      logic               active;
      logic               last;
   } voice_out_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  start;
      logic                  typed;
      logic signed [15:0]    sample;
      logic                  active;
      logic                  last;
      adsr_pkg::csr_reg_type index;
      logic [23:0]           data;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_start_req = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample;
   logic rsp_active;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   adsr_pkg::csr_reg_type csr_index = adsr_pkg::REG_WAVEFORM;
   logic [adsr_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   // Voice model state and its copy of the registers.
   adsr_pkg::cfg_type voice_cfg;
   logic [adsr_pkg::PHASE_BITS-1:0] phase_now;
   adsr_pkg::segment_type seg_now;
   logic [adsr_pkg::TIME_BITS-1:0] seg_pos;
   logic note_on;

   voice_out_type pending_samples[$];
   int mismatches = 0;
   int samples_seen = 0;

   always #CLK_HALF clock = ~clock;

   adsr_waveform_voice_top uut (.*);

   function automatic int sine_value(int unsigned idx);
      longint unsigned turn, x, xsq, acc, y, mag;
      int unsigned divisors[5];
      logic negative;
      divisors = '{110, 72, 42, 20, 6};
      turn = (longint'(idx) << 32) / adsr_pkg::SINE_DEPTH;
      negative = 1'b0;
      if (turn >= (64'd1 << 31)) begin
         negative = 1'b1;
         turn -= 64'd1 << 31;
      end
      if (turn > (64'd1 << 30)) turn = (64'd1 << 31) - turn;
      x = (turn * 64'd6746518852) >> 32;
      xsq = (x * x) >> 30;
      acc = 64'd1 << 30;
      foreach (divisors[i]) acc = (64'd1 << 30) - ((xsq * acc) >> 30) / divisors[i];
      y = (x * acc) >> 30;
      mag = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) mag = 64'd32767;
      return negative ? -int'(mag) : int'(mag);
   endfunction

   function automatic int wave_at(logic [adsr_pkg::PHASE_BITS-1:0] p);
      longint unsigned ramp;
      case (adsr_pkg::wave_type'(voice_cfg.waveform))
         adsr_pkg::WAVE_SINE:
            return sine_value((longint'(p) * adsr_pkg::SINE_DEPTH) >> adsr_pkg::PHASE_BITS);
         adsr_pkg::WAVE_SQUARE:
            return (p > 0 && p[adsr_pkg::PHASE_BITS-1] == 1'b0) ? 32767 : -32767;
         adsr_pkg::WAVE_TRIANGLE: begin
            ramp = (longint'(p[adsr_pkg::PHASE_BITS-3:0]) * 32767)
                   >> (adsr_pkg::PHASE_BITS - 2);
            case (p[adsr_pkg::PHASE_BITS-1:adsr_pkg::PHASE_BITS-2])
               2'd0: return int'(ramp);
               2'd1: return 32767 - int'(ramp);
               2'd2: return -int'(ramp);
               default: return int'(ramp) - 32767;
            endcase
         end
         default: begin
            ramp = (longint'(p[adsr_pkg::PHASE_BITS-2:0]) * 32767)
                   >> (adsr_pkg::PHASE_BITS - 1);
            return p[adsr_pkg::PHASE_BITS-1] ? int'(ramp) - 32767 : int'(ramp);
         end
      endcase
   endfunction

   function automatic longint envelope_level();
      longint unsigned peak, hold, len, n;
      peak = voice_cfg.attack_level > adsr_pkg::UNITY ? adsr_pkg::UNITY
                                                      : voice_cfg.attack_level;
      hold = voice_cfg.sustain_level > adsr_pkg::UNITY ? adsr_pkg::UNITY
                                                       : voice_cfg.sustain_level;
      len = voice_cfg.seg_len[seg_now];
      n = seg_pos;
      // A segment shortened under a playing note sits at its end value.
      if (len == 0) begin
         n = 1;
         len = 1;
      end else if (n > len) begin
         n = len;
      end
      case (seg_now)
         adsr_pkg::SEG_ATTACK: return peak * n / len;
         adsr_pkg::SEG_DECAY: begin
            if (peak >= hold) return peak - (peak - hold) * n / len;
            return peak + (hold - peak) * n / len;
         end
         adsr_pkg::SEG_SUSTAIN: return hold;
         default: return hold - hold * n / len;
      endcase
   endfunction

   function automatic void enter_segment(int first);
      for (int k = first; k < 4; k++) begin
         if (voice_cfg.seg_len[k] != 0) begin
            seg_now = adsr_pkg::segment_type'(k);
            seg_pos = '0;
            note_on = 1'b1;
            return;
         end
      end
      note_on = 1'b0;
      seg_now = adsr_pkg::SEG_ATTACK;
      seg_pos = '0;
   endfunction

   function automatic voice_out_type voice_tick(logic start);
      voice_out_type res;
      longint prod, mag;
      res = '{sample: '0, active: 1'b0, last: 1'b0};
      if (start) begin
         phase_now = '0;
         enter_segment(0);
      end
      if (!note_on) return res;
      prod = envelope_level() * longint'(wave_at(phase_now));
      mag = (prod < 0 ? -prod : prod) >>> 15;
      res.sample = 16'(prod < 0 ? -mag : mag);
      res.active = 1'b1;
      phase_now = phase_now + adsr_pkg::PHASE_BITS'(voice_cfg.phase_step);
      seg_pos = seg_pos + 1'b1;
      if (seg_pos == 0 || seg_pos >= voice_cfg.seg_len[seg_now]) begin
         enter_segment(int'(seg_now) + 1);
         res.last = !note_on;
      end
      return res;
   endfunction

   task automatic send_tick(logic start, logic typed, voice_out_type typed_out);
      int gap;
      voice_out_type predicted;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
      predicted = voice_tick(start);
      pending_samples.push_back(typed ? typed_out : predicted);
   endtask

   task automatic write_register(adsr_pkg::csr_reg_type idx, logic [23:0] value);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      // A transaction can still be inside the back end after the last response.
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         adsr_pkg::REG_WAVEFORM:
            voice_cfg.waveform = adsr_pkg::wave_type'(value[1:0]);
         adsr_pkg::REG_PHASE_STEP:
            voice_cfg.phase_step = value[adsr_pkg::STEP_BITS-1:0];
         adsr_pkg::REG_ATTACK_LEVEL: voice_cfg.attack_level = value[15:0];
         adsr_pkg::REG_SUSTAIN_LEVEL: voice_cfg.sustain_level = value[15:0];
         default: voice_cfg.seg_len[idx - adsr_pkg::REG_ATTACK_LEN] = value;
      endcase
   endtask

   function automatic logic [23:0] pick_length(int phase);
      if (phase == 7) return 24'hFFFFFF;
      if ($urandom_range(0, 3) == 0) return '0;
      return $urandom_range(1, 24);
   endfunction

   // Response side: random stalls, one long hold-off to back up the block.
   initial begin
      int gap;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (samples_seen == 500) gap = 300;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         samples_seen++;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response sample=%0d", rsp_sample);
         end else begin
            voice_out_type want;
            want = pending_samples.pop_front();
            if (want.sample !== rsp_sample || want.active !== rsp_active
                || want.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                           want.sample, want.active, want.last,
                           rsp_sample, rsp_active, rsp_last);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      row_type rows[$];
      voice_out_type typed_out;
      adsr_pkg::csr_reg_type order[8];
      logic [23:0] value;
      voice_cfg = '0;
      phase_now = '0;
      seg_now = adsr_pkg::SEG_ATTACK;
      seg_pos = '0;
      note_on = 1'b0;

      // Idle voice, then a start with every segment empty.
      rows.push_back('{ROW_ITEM, 0, 1, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 1, 1, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM,
                       adsr_pkg::WAVE_SQUARE});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_ATTACK_LEVEL, 24'hFFFF});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_ATTACK_LEN, 1});
      // A one-sample attack-only note: zero envelope, final sample flagged.
      rows.push_back('{ROW_ITEM, 1, 1, 0, 1, 1, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 0, 1, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_ATTACK_LEN, 4});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_DECAY_LEN, 2});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_RELEASE_LEN, 3});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_SUSTAIN_LEVEL, 24'h8000});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_PHASE_STEP, 24'h7FFFFF});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM,
                       adsr_pkg::WAVE_TRIANGLE});
      rows.push_back('{ROW_ITEM, 1, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      for (int i = 0; i < 10; i++) begin
         rows.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      end
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM,
                       adsr_pkg::WAVE_SAW});
      rows.push_back('{ROW_ITEM, 1, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_SUSTAIN_LEN, 5});
      rows.push_back('{ROW_CSR, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM,
                       adsr_pkg::WAVE_SINE});
      // Restart while the note is still playing.
      rows.push_back('{ROW_ITEM, 1, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 1, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});
      rows.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, adsr_pkg::REG_WAVEFORM, 0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            write_register(rows[i].index, rows[i].data);
         end else begin
            typed_out = '{sample: rows[i].sample, active: rows[i].active,
                          last: rows[i].last};
            send_tick(rows[i].start, rows[i].typed, typed_out);
         end
      end

      // Random phases; in the last one, each length or level written is the longest or extreme value.
      for (int phase = 0; phase < 8; phase++) begin
         order = '{adsr_pkg::REG_WAVEFORM, adsr_pkg::REG_PHASE_STEP,
                   adsr_pkg::REG_ATTACK_LEVEL, adsr_pkg::REG_SUSTAIN_LEVEL,
                   adsr_pkg::REG_ATTACK_LEN, adsr_pkg::REG_DECAY_LEN,
                   adsr_pkg::REG_SUSTAIN_LEN, adsr_pkg::REG_RELEASE_LEN};
         foreach (order[k]) begin
            case (order[k])
               adsr_pkg::REG_WAVEFORM: value = phase % 4;
               adsr_pkg::REG_PHASE_STEP:
                  value = (phase == 7) ? 24'h7FFFFF :
                          (phase == 6) ? 24'd0 : $urandom_range(0, 24'h7FFFFF);
               adsr_pkg::REG_ATTACK_LEVEL, adsr_pkg::REG_SUSTAIN_LEVEL:
                  value = (phase == 7) ? 24'hFFFF :
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16'hFFFF) :
                          $urandom_range(0, 32768);
               default: value = pick_length(phase);
            endcase
            if (phase < 2 || $urandom_range(0, 3) != 0) write_register(order[k], value);
         end
         for (int n = 0; n < 200; n++) begin
            send_tick(!note_on ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 19) == 0),
                      1'b0, typed_out);
         end
      end

      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
